// ===== rtl/fpsd_pkg.sv =====
// Shared types and constants for the form parameter stream decoder.
`timescale 1ns / 1ps
package fpsd_pkg;

    localparam int FIELD_MAX = 256;
    localparam int CNT_W     = $clog2(FIELD_MAX + 1);

    localparam logic [2:0] K_NAME_BYTE  = 3'd0;
    localparam logic [2:0] K_VALUE_BYTE = 3'd1;
    localparam logic [2:0] K_NAME_END   = 3'd2;
    localparam logic [2:0] K_PAIR_END   = 3'd3;
    localparam logic [2:0] K_ABANDON    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       truncated;
        logic       out_last;
    } t_out;

    // results caused by one input byte, slot 0 first
    typedef struct packed {
        logic [1:0]       n;
        t_out [2:0]       res;
    } t_grp;

endpackage

// ===== rtl/fpsd_core.sv =====
// Per-byte parser: state registers and the single-pass decode of one byte.
`timescale 1ns / 1ps
module fpsd_core
    import fpsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_in  i_item,
    output t_grp o_grp
);

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_ENDED = 2'd2;

    typedef struct packed {
        logic [1:0]       ph;
        logic [1:0]       edl;
        logic [7:0]       ev;
        logic             es;
        logic [CNT_W-1:0] fc;
        logic             fo;
        logic [1:0]       n;
        t_out [2:0]       res;
    } t_work;

    logic [1:0]       r_ph,  n_ph;
    logic [1:0]       r_edl, n_edl;
    logic [7:0]       r_ev,  n_ev;
    logic             r_es,  n_es;
    logic [CNT_W-1:0] r_fc,  n_fc;
    logic             r_fo,  n_fo;
    t_work            w;

    function automatic logic [4:0] f_hex(logic [7:0] b);
        logic [4:0] d;
        d = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = {1'b1, 4'(b - 8'h37)};
        end
        return d;
    endfunction

    function automatic t_work f_emit(t_work wi, logic [2:0] kind, logic [7:0] b, logic tr);
        t_work wo;
        t_out  r;
        wo          = wi;
        r.kind      = kind;
        r.out_byte  = b;
        r.truncated = tr;
        r.out_last  = 1'b0;
        wo.res[wo.n] = r;
        wo.n         = wo.n + 2'd1;
        return wo;
    endfunction

    function automatic t_work f_put(t_work wi, logic [7:0] b);
        t_work wo;
        wo = wi;
        if (wo.fc < CNT_W'(FIELD_MAX)) begin
            wo.fc = wo.fc + 1'b1;
            wo = f_emit(wo, (wo.ph == PH_NAME) ? K_NAME_BYTE : K_VALUE_BYTE, b, 1'b0);
        end else begin
            wo.fo = 1'b1;
        end
        return wo;
    endfunction

    function automatic t_work f_flush(t_work wi);
        t_work      wo;
        logic [7:0] v;
        wo = wi;
        v  = wo.ev;
        if (wo.edl != 2'd0) begin
            wo.edl = 2'd0;
            wo.ev  = 8'd0;
            wo.es  = 1'b0;
            wo = f_put(wo, v);
        end
        return wo;
    endfunction

    function automatic t_work f_close(t_work wi);
        t_work wo;
        wo = f_flush(wi);
        if (wo.ph == PH_NAME) begin
            wo = f_emit(wo, K_ABANDON, 8'd0, 1'b0);
        end else begin
            wo = f_emit(wo, K_PAIR_END, 8'd0, wo.fo);
        end
        return wo;
    endfunction

    function automatic t_work f_start(t_work wi);
        t_work wo;
        wo     = wi;
        wo.edl = 2'd0;
        wo.ev  = 8'd0;
        wo.es  = 1'b0;
        wo.fc  = '0;
        wo.fo  = 1'b0;
        return wo;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic [7:0] delim;
        logic [4:0] d;
        logic [7:0] v;
        logic       just;
        b     = i_item.in_byte;
        just  = 1'b0;
        d     = f_hex(b);
        w.ph  = r_ph;
        w.edl = r_edl;
        w.ev  = r_ev;
        w.es  = r_es;
        w.fc  = r_fc;
        w.fo  = r_fo;
        w.n   = 2'd0;
        w.res = '0;
        delim = (r_ph == PH_NAME) ? 8'h3D : 8'h26;
        v     = 8'd0;
        if (r_ph != PH_NAME && r_ph != PH_VALUE) begin
            if (i_item.in_last) begin
                w    = f_start(w);
                w.ph = PH_NAME;
            end
        end else if (b == 8'd0) begin
            w    = f_close(w);
            w.ph = PH_ENDED;
            w    = f_start(w);
            if (i_item.in_last) begin
                w.ph = PH_NAME;
            end
        end else begin
            if (b == delim) begin
                w = f_flush(w);
                if (w.ph == PH_NAME) begin
                    w    = f_emit(w, K_NAME_END, 8'd0, w.fo);
                    w.ph = PH_VALUE;
                end else begin
                    w    = f_emit(w, K_PAIR_END, 8'd0, w.fo);
                    w.ph = PH_NAME;
                    just = 1'b1;
                end
                w = f_start(w);
            end else if (w.edl != 2'd0) begin
                if (!d[4]) begin
                    w.es = 1'b1;
                end else if (!w.es) begin
                    w.ev = {w.ev[3:0], d[3:0]};
                end
                w.edl = w.edl - 2'd1;
                if (w.edl == 2'd0) begin
                    v    = w.ev;
                    w.ev = 8'd0;
                    w.es = 1'b0;
                    w    = f_put(w, v);
                end
            end else if (b == 8'h25) begin
                w.edl = 2'd2;
                w.ev  = 8'd0;
                w.es  = 1'b0;
            end else if (b == 8'h2B) begin
                w = f_put(w, 8'h20);
            end else begin
                w = f_put(w, b);
            end
            if (i_item.in_last) begin
                if (!(w.ph == PH_NAME && just)) begin
                    w = f_close(w);
                end
                w    = f_start(w);
                w.ph = PH_NAME;
            end
        end
        if (w.n != 2'd0) begin
            w.res[w.n - 2'd1].out_last = 1'b1;
        end
        n_ph  = w.ph;
        n_edl = w.edl;
        n_ev  = w.ev;
        n_es  = w.es;
        n_fc  = w.fc;
        n_fo  = w.fo;
    end

    assign o_grp.n   = w.n;
    assign o_grp.res = w.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_NAME;
            r_edl <= 2'd0;
            r_ev  <= 8'd0;
            r_es  <= 1'b0;
            r_fc  <= '0;
            r_fo  <= 1'b0;
        end else if (i_adv) begin
            r_ph  <= n_ph;
            r_edl <= n_edl;
            r_ev  <= n_ev;
            r_es  <= n_es;
            r_fc  <= n_fc;
            r_fo  <= n_fo;
        end
    end

endmodule

// ===== rtl/fpsd_out.sv =====
// Result register: holds the results of one byte and sends them one per transfer.
`timescale 1ns / 1ps
module fpsd_out
    import fpsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_grp i_grp,
    output logic o_free,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic       r_gv;
    logic [1:0] r_idx;
    t_grp       r_grp;
    logic       xfer;
    logic       done;

    assign o_valid = r_gv;
    assign o_data  = r_grp.res[r_idx];
    assign xfer    = r_gv && !i_stall;
    assign done    = xfer && o_data.out_last;
    assign o_free  = !r_gv || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv  <= 1'b0;
            r_idx <= 2'd0;
        end else if (i_load && i_grp.n != 2'd0) begin
            r_gv  <= 1'b1;
            r_idx <= 2'd0;
        end else if (done) begin
            r_gv  <= 1'b0;
        end else if (xfer) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

// ===== rtl/form_param_stream_decoder_unit.sv =====
// The input byte is registered, decoded combinationally, and its results are
// registered in the result register before they are valid on the output.
// Throughput: one byte per cycle while the output is not stalled and each byte gives
// at most one result; a byte that gives k results holds the result register until all k have transferred.
// Bytes that give no result never occupy the output.
// Reset (synchronous, active low) returns the parser to the name phase and
// drops any held byte or pending results.
`timescale 1ns / 1ps
module form_param_stream_decoder_unit
    import fpsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic r_iv;
    t_in  r_in;
    logic grp_free;
    logic adv;
    t_grp grp;

    assign adv     = r_iv && grp_free;
    assign o_stall = r_iv && !grp_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (!o_stall) begin
            r_iv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_data;
        end
    end

    fpsd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_grp   (grp)
    );

    fpsd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_grp   (grp),
        .o_free  (grp_free),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== tb/sv/form_param_stream_decoder_unit_tb.sv =====
// Self-checking testbench for the form parameter stream decoder: directed table, field overflow, random streams.
`timescale 1ns / 1ps
module form_param_stream_decoder_unit_tb;
    import fpsd_pkg::*;

    localparam logic [7:0] CH_EQ   = "=";
    localparam logic [7:0] CH_AMP  = "&";
    localparam logic [7:0] CH_PCT  = "%";
    localparam logic [7:0] CH_PLUS = "+";
    localparam logic [7:0] CH_SP   = " ";
    localparam t_out       NO_RES  = '0;
    localparam int         N_DIR   = 28;
    localparam int         N_RAND  = 24;

    typedef enum logic [1:0] {PH_NAME, PH_VALUE, PH_ENDED} t_phase;

    // known = 1: results typed in the table, else taken from the decoder copy
    typedef struct packed {
        t_in  d;
        logic known;
        t_grp grp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall;

    form_param_stream_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder copy
    t_phase      ph;
    logic [1:0]  esc_left;
    logic [7:0]  esc_val;
    logic        esc_stop;
    logic [16:0] fcount;
    logic        fovf;
    t_out        step_res[$];

    t_out        due_results[$];
    t_row        stim_q[$];
    t_row        dir_tab [N_DIR];
    int          mismatch_cnt = 0;
    int          n_checked = 0;
    int          burst_left = 0;
    string       alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string       hexch = "0123456789abcdefABCDEF";

    function automatic t_out res(input logic [2:0] k, input logic [7:0] b, input logic tr,
                                 input logic l);
        t_out r;
        r.kind      = k;
        r.out_byte  = b;
        r.truncated = tr;
        r.out_last  = l;
        return r;
    endfunction

    function automatic t_row row(input logic [7:0] b, input logic l);
        t_row r;
        r           = '0;
        r.d.in_byte = b;
        r.d.in_last = l;
        return r;
    endfunction

    function automatic t_row row_known(input logic [7:0] b, input logic l, input logic [1:0] n,
                                       input t_out r0, input t_out r1);
        t_row r;
        r            = row(b, l);
        r.known      = 1'b1;
        r.grp.n      = n;
        r.grp.res[0] = r0;
        r.grp.res[1] = r1;
        return r;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
        if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
        if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
        return 5'd0;
    endfunction

    task automatic clear_field();
        esc_left = 2'd0;
        esc_val  = 8'd0;
        esc_stop = 1'b0;
        fcount   = 17'd0;
        fovf     = 1'b0;
    endtask

    task automatic add_res(input logic [2:0] k, input logic [7:0] b, input logic tr);
        step_res.push_back(res(k, b, tr, 1'b0));
    endtask

    task automatic put_byte(input logic [7:0] b);
        if (fcount < 17'(FIELD_MAX)) begin
            fcount++;
            add_res((ph == PH_NAME) ? K_NAME_BYTE : K_VALUE_BYTE, b, 1'b0);
        end else begin
            fovf = 1'b1;
        end
    endtask

    task automatic flush_escape();
        logic [7:0] v;
        if (esc_left != 2'd0) begin
            v        = esc_val;
            esc_left = 2'd0;
            esc_val  = 8'd0;
            esc_stop = 1'b0;
            put_byte(v);
        end
    endtask

    task automatic close_open_field();
        flush_escape();
        if (ph == PH_NAME) add_res(K_ABANDON, 8'd0, 1'b0);
        else add_res(K_PAIR_END, 8'd0, fovf);
    endtask

    // results of one accepted byte land in step_res
    task automatic decode_step(input t_in d);
        logic       opened;
        logic [7:0] b;
        logic [7:0] v;
        logic [4:0] hx;
        step_res.delete();
        b      = d.in_byte;
        opened = 1'b0;
        if (ph == PH_ENDED) begin
            if (d.in_last) begin
                ph = PH_NAME;
                clear_field();
            end
        end else if (b == 8'd0) begin
            close_open_field();
            ph = d.in_last ? PH_NAME : PH_ENDED;
            clear_field();
        end else begin
            if (b == ((ph == PH_NAME) ? CH_EQ : CH_AMP)) begin
                flush_escape();
                if (ph == PH_NAME) begin
                    add_res(K_NAME_END, 8'd0, fovf);
                    ph = PH_VALUE;
                end else begin
                    add_res(K_PAIR_END, 8'd0, fovf);
                    ph     = PH_NAME;
                    opened = 1'b1;
                end
                clear_field();
            end else if (esc_left != 2'd0) begin
                hx = hex_nibble(b);
                if (!hx[4]) esc_stop = 1'b1;
                else if (!esc_stop) esc_val = {esc_val[3:0], hx[3:0]};
                esc_left--;
                if (esc_left == 2'd0) begin
                    v        = esc_val;
                    esc_val  = 8'd0;
                    esc_stop = 1'b0;
                    put_byte(v);
                end
            end else if (b == CH_PCT) begin
                esc_left = 2'd2;
                esc_val  = 8'd0;
                esc_stop = 1'b0;
            end else if (b == CH_PLUS) begin
                put_byte(CH_SP);
            end else begin
                put_byte(b);
            end
            if (d.in_last) begin
                if (!(ph == PH_NAME && opened)) close_open_field();
                ph = PH_NAME;
                clear_field();
            end
        end
        if (step_res.size() > 0) step_res[$].out_last = 1'b1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic l);
        stim_q.push_back(row(b, l));
    endtask

    task automatic add_field(input int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 19);
            if (roll < 12) begin
                push_byte(alnum[$urandom_range(0, alnum.len() - 1)], 1'b0);
            end else if (roll < 14) begin
                push_byte(CH_PLUS, 1'b0);
            end else if (roll < 17) begin
                push_byte(CH_PCT, 1'b0);
                repeat (2) begin
                    if ($urandom_range(0, 4) != 0)
                        push_byte(hexch[$urandom_range(0, hexch.len() - 1)], 1'b0);
                    else
                        push_byte(8'($urandom_range(1, 255)), 1'b0);
                end
            end else begin
                push_byte(8'($urandom_range(1, 255)), 1'b0);
            end
        end
    endtask

    task automatic add_run(input int n);
        for (int i = 0; i < n; i++) push_byte(8'(97 + i % 26), 1'b0);
    endtask

    task automatic build_directed();
        dir_tab = '{
            row_known("a", 1'b0, 2'd1, res(K_NAME_BYTE, "a", 1'b0, 1'b1), NO_RES),
            row_known(CH_PLUS, 1'b0, 2'd1, res(K_NAME_BYTE, CH_SP, 1'b0, 1'b1), NO_RES),
            row_known(CH_PCT, 1'b0, 2'd0, NO_RES, NO_RES),
            row("f", 1'b0),
            row_known("F", 1'b0, 2'd1, res(K_NAME_BYTE, 8'hFF, 1'b0, 1'b1), NO_RES),
            row_known(CH_AMP, 1'b0, 2'd1, res(K_NAME_BYTE, CH_AMP, 1'b0, 1'b1), NO_RES),
            row(CH_PCT, 1'b0),
            row("4", 1'b0),
            row("g", 1'b0),
            row_known(CH_EQ, 1'b0, 2'd1, res(K_NAME_END, 8'd0, 1'b0, 1'b1), NO_RES),
            row_known(CH_EQ, 1'b0, 2'd1, res(K_VALUE_BYTE, CH_EQ, 1'b0, 1'b1), NO_RES),
            row(8'hFF, 1'b0),
            row(CH_PCT, 1'b0),
            row("A", 1'b0),
            row(CH_AMP, 1'b0),
            row(CH_PCT, 1'b0),
            row_known(8'h00, 1'b0, 2'd2, res(K_NAME_BYTE, 8'd0, 1'b0, 1'b0),
                      res(K_ABANDON, 8'd0, 1'b0, 1'b1)),
            row_known("x", 1'b0, 2'd0, NO_RES, NO_RES),
            row_known(8'h80, 1'b1, 2'd0, NO_RES, NO_RES),
            row("k", 1'b0),
            row(CH_EQ, 1'b0),
            row_known(CH_AMP, 1'b1, 2'd1, res(K_PAIR_END, 8'd0, 1'b0, 1'b1), NO_RES),
            row_known("z", 1'b1, 2'd2, res(K_NAME_BYTE, "z", 1'b0, 1'b0),
                      res(K_ABANDON, 8'd0, 1'b0, 1'b1)),
            row(CH_PCT, 1'b0),
            row("1", 1'b0),
            row(CH_EQ, 1'b1),
            row_known(CH_EQ, 1'b0, 2'd1, res(K_NAME_END, 8'd0, 1'b0, 1'b1), NO_RES),
            row_known(8'h00, 1'b1, 2'd1, res(K_PAIR_END, 8'd0, 1'b0, 1'b1), NO_RES)
        };
        foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    endtask

    // name filled to the byte limit; the escape flushed at '=' is one byte past it
    task automatic build_overflow();
        add_run(FIELD_MAX);
        push_byte(CH_PCT, 1'b0);
        push_byte("4", 1'b0);
        push_byte(CH_EQ, 1'b0);
        push_byte(8'h00, 1'b1);
    endtask

    task automatic build_random();
        int count;
        int nz;
        int npairs;
        int mark;
        count = 0;
        while (count < N_RAND) begin
            if ($urandom_range(0, 9) == 0) begin
                nz = $urandom_range(1, 8);
                repeat (nz) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                count += nz;
            end else begin
                mark   = stim_q.size();
                npairs = $urandom_range(1, 4);
                for (int p = 0; p < npairs; p++) begin
                    add_field($urandom_range(0, 6));
                    push_byte(CH_EQ, 1'b0);
                    add_field($urandom_range(0, 6));
                    if (p < npairs - 1) push_byte(CH_AMP, 1'b0);
                end
                case ($urandom_range(0, 7))
                    0, 1, 2: begin
                        push_byte(8'h00, 1'b0);
                        count += stim_q.size() - mark;
                        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                        push_byte(8'($urandom_range(0, 255)), 1'b1);
                        mark = stim_q.size();
                    end
                    3, 4, 5: stim_q[$].d.in_last = 1'b1;
                    6: push_byte(CH_AMP, 1'b1);
                    default: ;
                endcase
                count += stim_q.size() - mark;
            end
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("%0t ns: %0s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        n_checked++;
        if (due_results.size() == 0) begin
            report_mismatch("result with none pending, kind", got.kind, 0);
            return;
        end
        want = due_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.out_byte !== want.out_byte) report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.truncated !== want.truncated)
            report_mismatch("truncated", got.truncated, want.truncated);
        if (got.out_last !== want.out_last) report_mismatch("out_last", got.out_last, want.out_last);
    endtask

    initial begin : source
        t_row cur;
        int   gap;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        ph      = PH_NAME;
        clear_field();
        build_directed();
        build_overflow();
        build_random();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_q.size() > 0) begin
            cur = stim_q.pop_front();
            gap = pick_gap();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= cur.d;
            do @(posedge i_clk); while (o_stall);
            decode_step(cur.d);
            if (cur.known) begin
                for (int i = 0; i < int'(cur.grp.n); i++) due_results.push_back(cur.grp.res[i]);
            end else begin
                foreach (step_res[i]) due_results.push_back(step_res[i]);
            end
        end
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin : sink
        int  hold;
        int  quiet;
        int  roll;
        logic long_done;
        hold      = 0;
        quiet     = 0;
        long_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_result(o_data);
            // one long hold-off so the block backs up into its input
            if (!long_done && n_checked >= 100) begin
                long_done = 1'b1;
                hold      = 400;
            end
            if (hold == 0 && quiet == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) quiet = $urandom_range(30, 120);
                else if (roll < 30) hold = $urandom_range(1, 3);
                else if (roll < 33) hold = $urandom_range(8, 40);
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                if (quiet > 0) quiet--;
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
